### rtl/core/xcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrc_pkg
// Shared types, control characters and helpers for the XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
package xcrc_pkg;

    localparam int KEY_BYTES_DEF = 32;
    localparam int SHORT_BLOCK   = 128;
    localparam int LONG_BLOCK    = 1024;

    localparam int IDX_W = 11;
    localparam int TMR_W = 16;

    // item kinds on the input channel
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // control characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_SUB = 8'h1A;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // configuration registers
    localparam int          CFG_ADDR_W       = 4;
    localparam logic [1:0]  REG_START_TMO    = 2'd0;
    localparam logic [1:0]  REG_C_INTERVAL   = 2'd1;
    localparam logic [1:0]  REG_BYTE_TMO     = 2'd2;
    localparam logic [15:0] START_TMO_RST    = 16'd60000;
    localparam logic [15:0] C_INTERVAL_RST   = 16'd1000;
    localparam logic [15:0] BYTE_TMO_RST     = 16'd10000;

    typedef enum logic [2:0] {
        STAT_BUSY       = 3'd0,
        STAT_PASS       = 3'd1,
        STAT_START_TMO  = 3'd2,
        STAT_BAD_HDR    = 3'd3,
        STAT_INCOMPLETE = 3'd4,
        STAT_BLK_ERR    = 3'd5,
        STAT_SIZE_ERR   = 3'd6,
        STAT_NO_EOT     = 3'd7
    } t_status;

    typedef struct packed {
        logic       has_tx;
        logic [7:0] tx_byte;
        logic       has_key;
        logic [7:0] key_byte;
        t_status    status;
        logic       last;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic tick;
        logic req_tick;
        logic byte_in;
        logic hdr;
        logic seq;
        logic seqc;
        logic data;
        logic crch;
        logic key_clr;
        logic key_adv;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       is_soh;
        logic       is_stx;
        logic       is_eot;
        logic       blk_done;
        logic       check_ok;
        logic       pad_ok;
        logic       start_to;
        logic       c_due;
        logic       byte_to;
        logic       key_last;
        logic [7:0] key_data;
    } t_dp_stat;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/core/xcrc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrc_in_if
// Input channel: start commands, received bytes and millisecond ticks.
// ----------------------------------------------------------------------------
interface xcrc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

### rtl/core/xcrc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrc_out_if
// Result channel: bytes to transmit, key bytes and status.
// ----------------------------------------------------------------------------
interface xcrc_out_if;
    logic       valid;
    logic       ready;
    logic       has_tx;
    logic [7:0] tx_byte;
    logic       has_key;
    logic [7:0] key_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output has_tx, output tx_byte, output has_key,
                    output key_byte, output status, output last, input ready);
    modport sink   (input valid, input has_tx, input tx_byte, input has_key,
                    input key_byte, input status, input last, output ready);
endinterface

### rtl/core/xcrc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrc_cfg
// APB register bank holding the three millisecond timer settings.
// ----------------------------------------------------------------------------
module xcrc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [xcrc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [xcrc_pkg::TMR_W-1:0]       o_start_tmo,
    output logic [xcrc_pkg::TMR_W-1:0]       o_c_interval,
    output logic [xcrc_pkg::TMR_W-1:0]       o_byte_tmo
);

    logic [xcrc_pkg::TMR_W-1:0] r_start_tmo;
    logic [xcrc_pkg::TMR_W-1:0] r_c_interval;
    logic [xcrc_pkg::TMR_W-1:0] r_byte_tmo;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_tmo  <= xcrc_pkg::START_TMO_RST;
            r_c_interval <= xcrc_pkg::C_INTERVAL_RST;
            r_byte_tmo   <= xcrc_pkg::BYTE_TMO_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                xcrc_pkg::REG_START_TMO:  r_start_tmo  <= pwdata[15:0];
                xcrc_pkg::REG_C_INTERVAL: r_c_interval <= pwdata[15:0];
                xcrc_pkg::REG_BYTE_TMO:   r_byte_tmo   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            xcrc_pkg::REG_START_TMO:  prdata = {16'h0000, r_start_tmo};
            xcrc_pkg::REG_C_INTERVAL: prdata = {16'h0000, r_c_interval};
            xcrc_pkg::REG_BYTE_TMO:   prdata = {16'h0000, r_byte_tmo};
            default:                  prdata = 32'h0000_0000;
        endcase
    end

    assign o_start_tmo  = r_start_tmo;
    assign o_c_interval = r_c_interval;
    assign o_byte_tmo   = r_byte_tmo;

endmodule

### rtl/core/xcrc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrc_dp
// Datapath: CRC, header fields, byte counter, timers and the key store.
// ----------------------------------------------------------------------------
module xcrc_dp #(
    parameter int KEY_BYTES = xcrc_pkg::KEY_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  xcrc_pkg::t_dp_cmd           i_cmd,
    input  logic [7:0]                  i_rx_byte,
    input  logic [xcrc_pkg::TMR_W-1:0]  i_start_tmo,
    input  logic [xcrc_pkg::TMR_W-1:0]  i_c_interval,
    input  logic [xcrc_pkg::TMR_W-1:0]  i_byte_tmo,
    output xcrc_pkg::t_dp_stat          o_stat
);

    localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int IW = xcrc_pkg::IDX_W;
    localparam int TW = xcrc_pkg::TMR_W;

    logic [15:0]   r_crc;
    logic [7:0]    r_chk_hi;
    logic [IW-1:0] r_idx;
    logic          r_long;
    logic [7:0]    r_seq;
    logic [7:0]    r_seqc;
    logic          r_pad_bad;
    logic [TW-1:0] r_wait;
    logic [TW-1:0] r_req;
    logic [KW-1:0] r_kcnt;
    logic [7:0]    r_key_rd;
    logic [7:0]    key_mem [KEY_BYTES];

    logic [TW-1:0] wait_nx;
    logic [TW-1:0] req_nx;
    logic [IW-1:0] idx_nx;
    logic [IW-1:0] blk_len;
    logic          in_key_area;
    logic          pad_byte_ok;
    logic [7:0]    seq_sum;

    assign wait_nx     = (r_wait == {TW{1'b1}}) ? r_wait : r_wait + 1'b1;
    assign req_nx      = (r_req == {TW{1'b1}}) ? r_req : r_req + 1'b1;
    assign idx_nx      = r_idx + 1'b1;
    assign blk_len     = r_long ? IW'(xcrc_pkg::LONG_BLOCK) : IW'(xcrc_pkg::SHORT_BLOCK);
    assign in_key_area = r_idx < IW'(KEY_BYTES);
    assign pad_byte_ok = (i_rx_byte == 8'h00) || (i_rx_byte == xcrc_pkg::CH_SUB);
    assign seq_sum     = r_seq + r_seqc;

    always_comb begin
        o_stat.is_soh   = i_rx_byte == xcrc_pkg::CH_SOH;
        o_stat.is_stx   = i_rx_byte == xcrc_pkg::CH_STX;
        o_stat.is_eot   = i_rx_byte == xcrc_pkg::CH_EOT;
        o_stat.blk_done = idx_nx >= blk_len;
        o_stat.check_ok = (r_seq == 8'h01) && (seq_sum == 8'hFF)
                          && ({r_chk_hi, i_rx_byte} == r_crc);
        o_stat.pad_ok   = !r_pad_bad;
        o_stat.start_to = wait_nx >= i_start_tmo;
        o_stat.c_due    = req_nx >= i_c_interval;
        o_stat.byte_to  = wait_nx >= i_byte_tmo;
        o_stat.key_last = r_kcnt == KW'(KEY_BYTES - 1);
        o_stat.key_data = r_key_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= '0;
            r_chk_hi  <= '0;
            r_idx     <= '0;
            r_long    <= 1'b0;
            r_seq     <= '0;
            r_seqc    <= '0;
            r_pad_bad <= 1'b0;
            r_wait    <= '0;
            r_req     <= '0;
            r_kcnt    <= '0;
        end else begin
            if (i_cmd.start) begin
                r_crc     <= '0;
                r_chk_hi  <= '0;
                r_idx     <= '0;
                r_long    <= 1'b0;
                r_seq     <= '0;
                r_seqc    <= '0;
                r_pad_bad <= 1'b0;
                r_wait    <= '0;
                r_req     <= '0;
            end
            if (i_cmd.tick) begin
                r_wait <= wait_nx;
            end
            if (i_cmd.req_tick) begin
                r_req <= o_stat.c_due ? '0 : req_nx;
            end
            if (i_cmd.byte_in) begin
                r_wait <= '0;
            end
            if (i_cmd.hdr) begin
                r_long    <= o_stat.is_stx;
                r_crc     <= '0;
                r_idx     <= '0;
                r_pad_bad <= 1'b0;
            end
            if (i_cmd.seq) begin
                r_seq <= i_rx_byte;
            end
            if (i_cmd.seqc) begin
                r_seqc <= i_rx_byte;
            end
            if (i_cmd.data) begin
                r_crc <= xcrc_pkg::crc_byte(r_crc, i_rx_byte);
                r_idx <= idx_nx;
                if (!in_key_area && !pad_byte_ok) begin
                    r_pad_bad <= 1'b1;
                end
            end
            if (i_cmd.crch) begin
                r_chk_hi <= i_rx_byte;
            end
            if (i_cmd.key_clr) begin
                r_kcnt <= '0;
            end else if (i_cmd.key_adv) begin
                r_kcnt <= r_kcnt + 1'b1;
            end
        end
    end

    // key store: written during the payload, read back after EOT
    always_ff @(posedge i_clk) begin
        if (i_cmd.data && in_key_area) begin
            key_mem[r_idx[KW-1:0]] <= i_rx_byte;
        end
        r_key_rd <= key_mem[r_kcnt];
    end

endmodule

### rtl/core/xcrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrc_ctrl
// Controller: protocol phase, per-item decision and result sequencing.
// ----------------------------------------------------------------------------
module xcrc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_func,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output xcrc_pkg::t_result   o_res,
    output xcrc_pkg::t_dp_cmd   o_cmd,
    input  xcrc_pkg::t_dp_stat  i_stat
);

    typedef enum logic [2:0] {
        P_IDLE, P_HEADER, P_SEQ, P_SEQC, P_DATA, P_CRCH, P_CRCL, P_EOT
    } t_phase;

    typedef enum logic [2:0] {
        ST_READY, ST_CAN1, ST_CAN2, ST_KFETCH, ST_KLOAD
    } t_state;

    typedef enum logic [2:0] {
        RES_NONE, RES_C, RES_ACK, RES_PASS, RES_FAIL, RES_FAIL_NAK
    } t_res_kind;

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic               r_out_valid, n_out_valid;
    xcrc_pkg::t_result  r_res, n_res;
    xcrc_pkg::t_status  r_status, n_status;

    t_res_kind          res_kind;
    xcrc_pkg::t_status  res_status;
    t_phase             dec_phase;
    logic               out_free;
    logic               in_fire;

    function automatic xcrc_pkg::t_result mk_tx(input logic [7:0] b,
                                                input xcrc_pkg::t_status s,
                                                input logic last);
        xcrc_pkg::t_result r;
        r.has_tx   = 1'b1;
        r.tx_byte  = b;
        r.has_key  = 1'b0;
        r.key_byte = 8'h00;
        r.status   = s;
        r.last     = last;
        return r;
    endfunction

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_READY) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // decide what an accepted item does
    always_comb begin
        res_kind   = RES_NONE;
        res_status = xcrc_pkg::STAT_BUSY;
        dec_phase  = r_phase;
        o_cmd      = '0;
        if (in_fire) begin
            case (i_func)
                xcrc_pkg::FUNC_START: begin
                    o_cmd.start = 1'b1;
                    dec_phase   = P_HEADER;
                    res_kind    = RES_C;
                end
                xcrc_pkg::FUNC_TICK: begin
                    if (r_phase != P_IDLE) begin
                        o_cmd.tick = 1'b1;
                        if (r_phase == P_HEADER) begin
                            o_cmd.req_tick = 1'b1;
                            if (i_stat.start_to) begin
                                res_kind   = RES_FAIL;
                                res_status = xcrc_pkg::STAT_START_TMO;
                                dec_phase  = P_IDLE;
                            end else if (i_stat.c_due) begin
                                res_kind = RES_C;
                            end
                        end else if (i_stat.byte_to) begin
                            res_kind   = RES_FAIL;
                            res_status = (r_phase == P_EOT) ? xcrc_pkg::STAT_NO_EOT
                                                            : xcrc_pkg::STAT_INCOMPLETE;
                            dec_phase  = P_IDLE;
                        end
                    end
                end
                xcrc_pkg::FUNC_BYTE: begin
                    if (r_phase != P_IDLE) begin
                        o_cmd.byte_in = 1'b1;
                    end
                    case (r_phase)
                        P_IDLE: ;
                        P_HEADER: begin
                            if (i_stat.is_soh || i_stat.is_stx) begin
                                o_cmd.hdr = 1'b1;
                                dec_phase = P_SEQ;
                            end else begin
                                res_kind   = RES_FAIL;
                                res_status = xcrc_pkg::STAT_BAD_HDR;
                                dec_phase  = P_IDLE;
                            end
                        end
                        P_SEQ: begin
                            o_cmd.seq = 1'b1;
                            dec_phase = P_SEQC;
                        end
                        P_SEQC: begin
                            o_cmd.seqc = 1'b1;
                            dec_phase  = P_DATA;
                        end
                        P_DATA: begin
                            o_cmd.data = 1'b1;
                            if (i_stat.blk_done) begin
                                dec_phase = P_CRCH;
                            end
                        end
                        P_CRCH: begin
                            o_cmd.crch = 1'b1;
                            dec_phase  = P_CRCL;
                        end
                        P_CRCL: begin
                            if (!i_stat.check_ok) begin
                                res_kind   = RES_FAIL_NAK;
                                res_status = xcrc_pkg::STAT_BLK_ERR;
                                dec_phase  = P_IDLE;
                            end else if (!i_stat.pad_ok) begin
                                res_kind   = RES_FAIL_NAK;
                                res_status = xcrc_pkg::STAT_SIZE_ERR;
                                dec_phase  = P_IDLE;
                            end else begin
                                res_kind  = RES_ACK;
                                dec_phase = P_EOT;
                            end
                        end
                        P_EOT: begin
                            dec_phase = P_IDLE;
                            if (i_stat.is_eot) begin
                                o_cmd.key_clr = 1'b1;
                                res_kind      = RES_PASS;
                                res_status    = xcrc_pkg::STAT_PASS;
                            end else begin
                                res_kind   = RES_FAIL;
                                res_status = xcrc_pkg::STAT_NO_EOT;
                            end
                        end
                        default: dec_phase = P_IDLE;
                    endcase
                end
                default: ;
            endcase
        end
        if (r_state == ST_KLOAD && out_free && !i_stat.key_last) begin
            o_cmd.key_adv = 1'b1;
        end
    end

    // result sequencing
    always_comb begin
        n_state     = r_state;
        n_phase     = dec_phase;
        n_status    = r_status;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_READY: begin
                if (in_fire) begin
                    n_status = res_status;
                    case (res_kind)
                        RES_NONE: ;
                        RES_C: begin
                            n_out_valid = 1'b1;
                            n_res       = mk_tx(xcrc_pkg::CH_C, res_status, 1'b1);
                        end
                        RES_ACK: begin
                            n_out_valid = 1'b1;
                            n_res       = mk_tx(xcrc_pkg::CH_ACK, res_status, 1'b1);
                        end
                        RES_PASS: begin
                            n_out_valid = 1'b1;
                            n_res       = mk_tx(xcrc_pkg::CH_ACK, res_status, 1'b0);
                            n_state     = ST_KFETCH;
                        end
                        RES_FAIL: begin
                            n_out_valid = 1'b1;
                            n_res       = mk_tx(xcrc_pkg::CH_CAN, res_status, 1'b0);
                            n_state     = ST_CAN2;
                        end
                        RES_FAIL_NAK: begin
                            n_out_valid = 1'b1;
                            n_res       = mk_tx(xcrc_pkg::CH_NAK, res_status, 1'b0);
                            n_state     = ST_CAN1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CAN1: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res       = mk_tx(xcrc_pkg::CH_CAN, r_status, 1'b0);
                    n_state     = ST_CAN2;
                end
            end
            ST_CAN2: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res       = mk_tx(xcrc_pkg::CH_CAN, r_status, 1'b1);
                    n_state     = ST_READY;
                end
            end
            ST_KFETCH: begin
                // wait for the registered read of the key store
                n_state = ST_KLOAD;
            end
            ST_KLOAD: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_res.has_tx   = 1'b0;
                    n_res.tx_byte  = 8'h00;
                    n_res.has_key  = 1'b1;
                    n_res.key_byte = i_stat.key_data;
                    n_res.status   = r_status;
                    n_res.last     = i_stat.key_last;
                    n_state        = i_stat.key_last ? ST_READY : ST_KFETCH;
                end
            end
            default: n_state = ST_READY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READY;
            r_phase     <= P_IDLE;
            r_out_valid <= 1'b0;
            r_status    <= xcrc_pkg::STAT_BUSY;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
        end
        r_res <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    a_ready_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_READY) |-> !o_in_ready)
        else $error("input ready while a result sequence is in progress");

    a_key_is_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.has_key) |->
            (r_res.status == xcrc_pkg::STAT_PASS) && !r_res.has_tx)
        else $error("key item without pass status");

    a_fail_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.status != xcrc_pkg::STAT_BUSY)
            && (r_res.status != xcrc_pkg::STAT_PASS)) |-> (r_phase == P_IDLE))
        else $error("failure reported but reception still active");

    a_last_ends_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.last) |-> (r_state == ST_READY))
        else $error("final item shown while sequence continues");

endmodule

### rtl/core/xmodem_crc_single_block_receiver_top.sv
`timescale 1ns / 1ps
// An accepted item's first result is registered and shown on the output in the next cycle.
// One item per cycle is taken while no result sequence runs and the output is free; C and
// ACK answers are single items; CAN sequences and the key readout hold the input, and the
// readout uses a fetch and a load state per key byte, for the key store's registered read.
// Reset: synchronous, active low; clears phase, timers, counters and the output valid flag.
// The key store has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
// xmodem_crc_single_block_receiver_top
// Receives one XMODEM-CRC block, answers the sender and delivers the key bytes.
// ----------------------------------------------------------------------------
module xmodem_crc_single_block_receiver_top #(
    parameter int KEY_BYTES = xcrc_pkg::KEY_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    xcrc_in_if.sink                          i_item,
    xcrc_out_if.source                       o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [xcrc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [xcrc_pkg::TMR_W-1:0] start_tmo;
    logic [xcrc_pkg::TMR_W-1:0] c_interval;
    logic [xcrc_pkg::TMR_W-1:0] byte_tmo;
    xcrc_pkg::t_dp_cmd          dp_cmd;
    xcrc_pkg::t_dp_stat         dp_stat;
    xcrc_pkg::t_result          res;

    xcrc_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_start_tmo  (start_tmo),
        .o_c_interval (c_interval),
        .o_byte_tmo   (byte_tmo)
    );

    xcrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_func      (i_item.func),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_res       (res),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    xcrc_dp #(
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_rx_byte    (i_item.rx_byte),
        .i_start_tmo  (start_tmo),
        .i_c_interval (c_interval),
        .i_byte_tmo   (byte_tmo),
        .o_stat       (dp_stat)
    );

    assign o_result.has_tx   = res.has_tx;
    assign o_result.tx_byte  = res.tx_byte;
    assign o_result.has_key  = res.has_key;
    assign o_result.key_byte = res.key_byte;
    assign o_result.status   = res.status;
    assign o_result.last     = res.last;

endmodule
